/* rtl/core/lkv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int          CFG_W     = 5;
  localparam logic [4:0]  CFG_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_COMMIT
  } lkv_state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic resolve;
    logic commit;
  } lkv_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/lkv_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lkv_ctrl
  import lkv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lkv_cmd_t      cmd
);

  lkv_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_MATCH;
      ST_MATCH:   state_nxt = ST_RESOLVE;
      ST_RESOLVE: state_nxt = ST_COMMIT;
      ST_COMMIT:  if (slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.capture = in_valid && (state_r == ST_IDLE);
    cmd.match   = (state_r == ST_MATCH);
    cmd.resolve = (state_r == ST_RESOLVE);
    cmd.commit  = (state_r == ST_COMMIT) && slot_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/lkv_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module lkv_datapath
  import lkv_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lkv_cmd_t              cmd,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data,
  input  wire logic                  in_func,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [VALUE_BITS-1:0] in_write_value,
  output logic                       out_found,
  output logic [VALUE_BITS-1:0]      out_read_value
);

  localparam int RW   = $clog2(CAPACITY);
  localparam int OW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (OW > CFG_W) ? OW : CFG_W;

  logic                  func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] wval_r;

  logic [CAPACITY-1:0]   valid_r;
  logic [KEY_BITS-1:0]   keys_r  [CAPACITY];
  logic [RW-1:0]         rank_r  [CAPACITY];
  logic [VALUE_BITS-1:0] mem     [CAPACITY];
  logic [OW-1:0]         occ_r;
  logic [CFG_W-1:0]      cap_r;

  logic [CAPACITY-1:0]   match_r;
  logic [VALUE_BITS-1:0] rdata_r;
  logic                  found_r;
  logic                  insert_r;
  logic [CAPACITY-1:0]   tgt_oh_r;
  logic [RW-1:0]         tgt_idx_r;
  logic [RW-1:0]         pivot_r;

  logic                  out_found_r;
  logic [VALUE_BITS-1:0] out_value_r;

  logic [CAPACITY-1:0]   hit_oh, free_oh, victim_vec, victim_oh, tgt_oh;
  logic [RW-1:0]         hit_idx, tgt_idx, hit_rank, occ_m1, pivot;
  logic [CMPW-1:0]       cap_ext, occ_ext, eff_cap;
  logic                  found, evict, is_put;

  function automatic logic [RW-1:0] oh_to_idx(input logic [CAPACITY-1:0] oh);
    logic [RW-1:0] idx;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (oh[i]) idx = idx | RW'(i);
    end
    return idx;
  endfunction

  assign is_put  = (func_r == FUNC_PUT);
  assign found   = |match_r;
  assign hit_oh  = match_r & (~match_r + CAPACITY'(1));
  assign free_oh = ~valid_r & (valid_r + CAPACITY'(1));
  assign occ_m1  = RW'(occ_r - OW'(1));

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      victim_vec[i] = valid_r[i] && (rank_r[i] == occ_m1);
      if (hit_oh[i]) hit_rank = hit_rank | rank_r[i];
    end
  end

  assign victim_oh = victim_vec & (~victim_vec + CAPACITY'(1));

  always_comb begin
    cap_ext = CMPW'(cap_r);
    occ_ext = CMPW'(occ_r);
    priority if (cap_r == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(CAPACITY)) begin
      eff_cap = CMPW'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict = is_put && !found && (occ_ext >= eff_cap) && (occ_r != '0);

  always_comb begin
    priority if (found) begin
      tgt_oh = hit_oh;
      pivot  = hit_rank;
    end else if (evict) begin
      tgt_oh = victim_oh;
      pivot  = occ_m1;
    end else begin
      tgt_oh = free_oh;
      pivot  = RW'(occ_r);
    end
  end

  assign hit_idx = oh_to_idx(hit_oh);
  assign tgt_idx = oh_to_idx(tgt_oh);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      key_r  <= in_key;
      wval_r <= in_write_value;
    end
    if (cmd.match) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= valid_r[i] && (keys_r[i] == key_r);
      end
    end
    if (cmd.resolve) begin
      found_r   <= found;
      insert_r  <= is_put && !found && !evict;
      tgt_oh_r  <= tgt_oh;
      tgt_idx_r <= tgt_idx;
      pivot_r   <= pivot;
    end
    if (cmd.commit) begin
      out_found_r <= found_r;
      out_value_r <= (!is_put && found_r) ? rdata_r : '0;
      if (found_r || is_put) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (tgt_oh_r[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < pivot_r)) begin
            rank_r[i] <= rank_r[i] + RW'(1);
          end
        end
      end
      if (is_put) begin
        keys_r[tgt_idx_r] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      rdata_r <= mem[hit_idx];
    end
    if (cmd.commit && is_put) begin
      mem[tgt_idx_r] <= wval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= CFG_RESET;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.commit && is_put) begin
        valid_r <= valid_r | tgt_oh_r;
        if (insert_r) occ_r <= occ_r + OW'(1);
      end
    end
  end

  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;

endmodule

`default_nettype wire

/* rtl/core/lru_key_value_cache.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports
// in        input      in_valid, in_ready, in_func, in_key, in_write_value
// out       output     out_valid, out_ready, out_found, out_read_value
// cfg       input      cfg_wr_en, cfg_wr_data
//
// Each item goes in order through accept, key compare across all entries,
// hit/victim/free-slot resolve with the value memory read, then commit.
// The sequencer handles one item at a time; the next transfer is taken
// the cycle after commit. Commit holds while the output register is full
// and out_ready is low. Synchronous reset empties the store at once.

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_func,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [VALUE_BITS-1:0] in_write_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_found,
  output logic [VALUE_BITS-1:0]      out_read_value,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data
);

  lkv_cmd_t cmd;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .out_found      (out_found),
    .out_read_value (out_read_value)
  );

endmodule

`default_nettype wire

/* tb/sv/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps

typedef struct {
  logic                                found;
  logic [lkv_pkg::DEF_VALUE_BITS-1:0]  value;
} lookup_result_t;

class cache_scoreboard;
  localparam int SLOTS = lkv_pkg::DEF_CAPACITY;
  localparam int KW    = lkv_pkg::DEF_KEY_BITS;
  localparam int VW    = lkv_pkg::DEF_VALUE_BITS;

  bit                     slot_live [SLOTS];
  logic [KW-1:0]          slot_key  [SLOTS];
  logic [VW-1:0]          slot_val  [SLOTS];
  int unsigned            slot_age  [SLOTS];
  int unsigned            fill;
  logic [lkv_pkg::CFG_W-1:0] cap_word;
  lookup_result_t         pending_lookups[$];
  int unsigned            mismatches;

  function new();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_age[i]  = 0;
    end
    fill       = 0;
    cap_word   = lkv_pkg::CFG_RESET;
    mismatches = 0;
  endfunction

  function void set_capacity(logic [lkv_pkg::CFG_W-1:0] word);
    cap_word = word;
  endfunction

  function int unsigned cap_limit();
    int unsigned c;
    c = cap_word;
    if (c < 1) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function int unsigned outstanding();
    return pending_lookups.size();
  endfunction

  // Move slot s of age r to the front; younger entries age by one.
  function void make_newest(int s, int unsigned r);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && i != s && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function void note_request(logic func, logic [KW-1:0] key, logic [VW-1:0] wval);
    lookup_result_t res;
    int             i;
    int             hit;
    int             slot;
    int unsigned    last;
    hit = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
    end
    res.found = (hit >= 0);
    res.value = '0;
    if (func == lkv_pkg::FUNC_GET) begin
      if (hit >= 0) begin
        res.value = slot_val[hit];
        make_newest(hit, slot_age[hit]);
      end
    end else if (hit >= 0) begin
      slot_val[hit] = wval;
      make_newest(hit, slot_age[hit]);
    end else if (fill >= cap_limit() && fill > 0) begin
      // evict the oldest entry and reuse its slot
      last = fill - 1;
      slot = 0;
      for (i = SLOTS - 1; i >= 0; i--) begin
        if (slot_live[i] && slot_age[i] == last) slot = i;
      end
      slot_key[slot] = key;
      slot_val[slot] = wval;
      make_newest(slot, last);
    end else begin
      slot = 0;
      for (i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_live[i]) slot = i;
      end
      for (i = 0; i < SLOTS; i++) begin
        if (slot_live[i]) slot_age[i]++;
      end
      slot_live[slot] = 1'b1;
      slot_key[slot]  = key;
      slot_val[slot]  = wval;
      slot_age[slot]  = 0;
      fill++;
    end
    pending_lookups.push_back(res);
  endfunction

  function void check_response(logic found, logic [VW-1:0] value);
    lookup_result_t want;
    if (pending_lookups.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: found=%0b value=%h", found, value);
      return;
    end
    want = pending_lookups.pop_front();
    if (found !== want.found || value !== want.value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected found=%0b value=%h, got found=%0b value=%h",
                 want.found, want.value, found, value);
    end
  endfunction
endclass

module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int KW         = DEF_KEY_BITS;
  localparam int VW         = DEF_VALUE_BITS;
  localparam int POOL       = 48;
  localparam int HANG_LIMIT = 3000;
  localparam int HOLD_LEN   = 300;

  typedef enum int {RX_STALL, RX_RANDOM, RX_OPEN} rx_style_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic              in_func        = FUNC_GET;
  logic [KW-1:0]     in_key         = '0;
  logic [VW-1:0]     in_write_value = '0;
  logic              out_valid;
  logic              out_ready;
  logic              out_found;
  logic [VW-1:0]     out_read_value;
  logic              cfg_wr_en      = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data    = '0;

  cache_scoreboard   sb = new();
  logic [KW-1:0]     key_pool [POOL];
  int unsigned       burst_left = 0;
  bit                long_hold_req = 1'b0;

  lru_key_value_cache DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // sample transfers mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_response(out_found, out_read_value);
      if (in_valid && in_ready) sb.note_request(in_func, in_key, in_write_value);
    end
  end

  task automatic push_item(input logic func, input logic [KW-1:0] key,
                           input logic [VW-1:0] wval);
    bit took;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_key         <= key;
    in_write_value <= wval;
    do begin
      @(negedge clk);
      took = in_valid && in_ready;
      @(posedge clk);
    end while (!took);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic release_input();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] word);
    release_input();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(word);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned span);
    int unsigned   n;
    logic          func;
    logic [KW-1:0] key;
    for (n = 0; n < count; n++) begin
      func = $urandom_range(0, 1) ? FUNC_PUT : FUNC_GET;
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, span - 1)];
      push_item(func, key, $urandom);
    end
  endtask

  initial begin
    rx_style_t   style;
    int unsigned run_left;
    out_ready = 1'b0;
    style     = RX_OPEN;
    run_left  = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        // hold off long enough for the cache to back up its input
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 24);
          style    = rx_style_t'($urandom_range(0, 2));
        end
        run_left--;
        case (style)
          RX_STALL:  out_ready <= 1'b0;
          RX_RANDOM: out_ready <= $urandom_range(0, 1);
          default:   out_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned i;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_capacity(5'd0);
    push_item(FUNC_GET, '0, $urandom);
    push_item(FUNC_PUT, '0, '1);
    push_item(FUNC_PUT, '1, '0);
    push_item(FUNC_GET, '0, $urandom);
    push_item(FUNC_GET, '1, '1);
    run_random(170, 3);

    write_capacity(5'd1);
    run_random(170, 3);

    write_capacity(5'd2);
    push_item(FUNC_PUT, 32'd1, 32'd1);
    push_item(FUNC_PUT, 32'd2, 32'd2);
    push_item(FUNC_GET, '1, $urandom);
    push_item(FUNC_GET, 32'd1, $urandom);
    push_item(FUNC_PUT, 32'd1, 32'hA5A5_A5A5);
    push_item(FUNC_GET, 32'd1, '0);
    run_random(170, 6);

    write_capacity(5'd4);
    long_hold_req = 1'b1;
    run_random(170, 8);

    write_capacity(5'd17);
    for (i = 0; i < 14; i++) push_item(FUNC_PUT, 32'h100 + i, $urandom);
    run_random(170, 22);

    write_capacity(5'd31);
    run_random(170, 24);

    write_capacity(5'd16);
    run_random(170, 20);

    // drop capacity below the current fill
    write_capacity(5'd3);
    run_random(170, 8);

    write_capacity(5'd8);
    run_random(170, 14);

    release_input();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
